// ===== rtl/core/adts_pkg.sv =====
package adts_pkg;

	localparam int unsigned HDR_BYTES = 7;
	localparam int unsigned DIV_STEPS = 23;

	typedef enum logic [3:0] {
		ST_BYTE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [1:0] {
		MODE_GATHER  = 2'd0,
		MODE_PAYLOAD = 2'd1,
		MODE_HUNT    = 2'd2
	} mode_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SYNC  = 2'd1;
	localparam logic [1:0] STAT_FREQ  = 2'd2;
	localparam logic [1:0] STAT_SHORT = 2'd3;

	localparam logic [11:0] SYNCWORD = 12'hfff;

	function automatic logic [16:0] rate_lookup(input logic [3:0] idx);
		logic [16:0] r;
		case (idx)
			4'd0:    r = 17'd96000;
			4'd1:    r = 17'd88200;
			4'd2:    r = 17'd64000;
			4'd3:    r = 17'd48000;
			4'd4:    r = 17'd44100;
			4'd5:    r = 17'd32000;
			4'd6:    r = 17'd24000;
			4'd7:    r = 17'd22050;
			4'd8:    r = 17'd16000;
			4'd9:    r = 17'd12000;
			4'd10:   r = 17'd11025;
			4'd11:   r = 17'd8000;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/adts_stream_header_parser_core.sv =====
// Payload and hunt bytes: one item per cycle while no header result is pending, no result.
// Header with an error: result valid the cycle after the seventh byte.
// Good header: result after a multiply state, then a one-bit-per-cycle restoring
// divider by raw_blocks+1 over 23 quotient bits; input stalls meanwhile.
// Reset (arst_n low) puts the parser in header gathering with nothing pending.
module adts_stream_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        mpeg_id,
	output logic        no_crc,
	output logic [1:0]  profile,
	output logic [3:0]  freq_index,
	output logic [2:0]  channel_config,
	output logic [6:0]  header_flags,
	output logic [12:0] frame_bytes,
	output logic [10:0] buffer_fullness,
	output logic [1:0]  raw_blocks,
	output logic [16:0] rate_hz,
	output logic [22:0] bits_per_sec
);
	import adts_pkg::*;

	state_t      state_q;
	mode_t       mode_q;
	logic [47:0] hdr_q;
	logic [2:0]  cnt_q;
	logic [12:0] pay_q;
	logic        saw_ff_q;

	logic [22:0] quo_q;
	logic [1:0]  rem_q;
	logic [4:0]  step_q;

	logic [1:0]  status_q;
	logic        mpeg_id_q;
	logic        no_crc_q;
	logic [1:0]  profile_q;
	logic [3:0]  freq_index_q;
	logic [2:0]  channel_config_q;
	logic [6:0]  header_flags_q;
	logic [12:0] frame_bytes_q;
	logic [10:0] buffer_fullness_q;
	logic [1:0]  raw_blocks_q;
	logic [16:0] rate_hz_q;

	logic        accept;
	logic [55:0] h;
	logic [16:0] rate;
	logic [1:0]  stat;
	logic [12:0] flen;
	logic [12:0] pay_dec;
	logic [12:0] pay_new;
	logic [29:0] product;
	logic [2:0]  divisor;
	logic [2:0]  trial;
	logic        fits;

	assign accept  = in_valid && in_ready;
	assign h       = {hdr_q, in_byte};
	assign flen    = h[25:13];
	assign rate    = rate_lookup(h[37:34]);
	assign pay_dec = pay_q - 13'd1;
	assign pay_new = flen - 13'(HDR_BYTES);

	always_comb begin
		if (h[55:44] != SYNCWORD) begin
			stat = STAT_SYNC;
		end else if (rate == 17'd0) begin
			stat = STAT_FREQ;
		end else if (flen < 13'(HDR_BYTES)) begin
			stat = STAT_SHORT;
		end else begin
			stat = STAT_OK;
		end
	end

	// shared unit: frame bytes*rate, then divide (product>>7) by blocks+1
	assign product = 30'(frame_bytes_q) * 30'(rate_hz_q);
	assign divisor = 3'(raw_blocks_q) + 3'd1;
	assign trial   = {rem_q, quo_q[22]};
	assign fits    = (trial >= divisor);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_BYTE;
			mode_q   <= MODE_GATHER;
			hdr_q    <= '0;
			cnt_q    <= '0;
			pay_q    <= '0;
			saw_ff_q <= 1'b0;
			step_q   <= '0;
		end else begin
			unique case (state_q)
				ST_BYTE: begin
					if (accept) begin
						case (mode_q)
							MODE_PAYLOAD: begin
								pay_q <= pay_dec;
								if (pay_dec == 13'd0) begin
									mode_q   <= MODE_GATHER;
									hdr_q    <= '0;
									cnt_q    <= '0;
									saw_ff_q <= 1'b0;
								end
							end
							MODE_HUNT: begin
								if (saw_ff_q && in_byte[7:4] == 4'hf) begin
									hdr_q    <= {32'd0, 8'hff, in_byte};
									cnt_q    <= 3'd2;
									saw_ff_q <= 1'b0;
									mode_q   <= MODE_GATHER;
								end else begin
									saw_ff_q <= (in_byte == 8'hff);
								end
							end
							default: begin
								mode_q <= MODE_GATHER;
								if (cnt_q == 3'(HDR_BYTES - 1)) begin
									hdr_q    <= '0;
									cnt_q    <= '0;
									saw_ff_q <= 1'b0;
									if (stat == STAT_OK) begin
										pay_q   <= pay_new;
										mode_q  <= (pay_new != 13'd0) ? MODE_PAYLOAD
										                              : MODE_GATHER;
										state_q <= ST_MUL;
									end else begin
										pay_q   <= '0;
										mode_q  <= MODE_HUNT;
										state_q <= ST_OUT;
									end
								end else begin
									hdr_q <= h[47:0];
									cnt_q <= cnt_q + 3'd1;
								end
							end
						endcase
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_BYTE;
					end
				end
				default: state_q <= ST_BYTE;
			endcase
		end
	end

	// result and divider datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_BYTE && accept && cnt_q == 3'(HDR_BYTES - 1)
		    && mode_q != MODE_PAYLOAD && mode_q != MODE_HUNT) begin
			status_q <= stat;
			quo_q    <= '0;
			if (stat == STAT_SYNC) begin
				mpeg_id_q         <= 1'b0;
				no_crc_q          <= 1'b0;
				profile_q         <= '0;
				freq_index_q      <= '0;
				channel_config_q  <= '0;
				header_flags_q    <= '0;
				frame_bytes_q     <= '0;
				buffer_fullness_q <= '0;
				raw_blocks_q      <= '0;
			end else begin
				mpeg_id_q         <= h[43];
				no_crc_q          <= h[40];
				profile_q         <= h[39:38];
				freq_index_q      <= h[37:34];
				channel_config_q  <= h[32:30];
				header_flags_q    <= {h[42:41], h[26], h[27], h[28], h[29], h[33]};
				frame_bytes_q     <= flen;
				buffer_fullness_q <= h[12:2];
				raw_blocks_q      <= h[1:0];
			end
			rate_hz_q <= (stat == STAT_OK) ? rate : 17'd0;
		end else if (state_q == ST_MUL) begin
			quo_q <= product[29:7];
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? 2'(trial - divisor) : trial[1:0];
			quo_q <= {quo_q[21:0], fits};
		end
	end

	assign in_ready        = (state_q == ST_BYTE);
	assign out_valid       = (state_q == ST_OUT);
	assign status          = status_q;
	assign mpeg_id         = mpeg_id_q;
	assign no_crc          = no_crc_q;
	assign profile         = profile_q;
	assign freq_index      = freq_index_q;
	assign channel_config  = channel_config_q;
	assign header_flags    = header_flags_q;
	assign frame_bytes     = frame_bytes_q;
	assign buffer_fullness = buffer_fullness_q;
	assign raw_blocks      = raw_blocks_q;
	assign rate_hz         = rate_hz_q;
	assign bits_per_sec    = quo_q;

endmodule
